/* design/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial-division prime tester: sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

	// sequencer states
	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_DIV  = 1'b1
	} tdpt_state_t;

endpackage : tdpt_pkg

`default_nettype wire

/* design/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Candidates 0 to 3 are answered from the idle state without trial division;
// otherwise each trial divisor from 2 up to candidate/2 is tried in turn
// (bit-serial restoring remainder), stopping at the first exact divisor.
// Throughput: one candidate at a time; for candidates of four and up busy stays high until the done strobe.
// The receiver cannot stall: done is high for exactly one cycle per result.
// Reset (arst_n low, asynchronous) returns the block to idle with done low.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int NUM_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [NUM_WIDTH-1:0] candidate,
	input  wire logic                 range_end,
	output logic                      done,
	output logic [NUM_WIDTH-1:0]      tested_value,
	output logic                      is_prime,
	output logic                      last_of_run
);

	localparam int CNT_W = (NUM_WIDTH > 2) ? $clog2(NUM_WIDTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

	// control registers
	tdpt_state_t state_q, state_d;
	logic        done_q, done_d;

	// working and result registers
	logic [NUM_WIDTH-1:0] num_q, num_d;
	logic                 last_q, last_d;
	logic [NUM_WIDTH-1:0] shift_q, shift_d;
	logic [NUM_WIDTH-1:0] rem_q, rem_d;
	logic [NUM_WIDTH-1:0] div_q, div_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [NUM_WIDTH-1:0] tested_value_q, tested_value_d;
	logic                 is_prime_q, is_prime_d;
	logic                 last_of_run_q, last_of_run_d;

	// one restoring step of the serial remainder
	logic [NUM_WIDTH:0]   trial;
	logic [NUM_WIDTH:0]   trial_sub;
	logic [NUM_WIDTH-1:0] rem_step;
	logic [NUM_WIDTH-1:0] limit;

	assign trial     = {rem_q, shift_q[NUM_WIDTH-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign rem_step  = (trial >= {1'b0, div_q}) ? trial_sub[NUM_WIDTH-1:0]
	                                            : trial[NUM_WIDTH-1:0];
	assign limit     = num_q >> 1;

	// next state and outputs
	always_comb begin
		state_d        = state_q;
		done_d         = 1'b0;
		num_d          = num_q;
		last_d         = last_q;
		shift_d        = shift_q;
		rem_d          = rem_q;
		div_d          = div_q;
		cnt_d          = cnt_q;
		tested_value_d = tested_value_q;
		is_prime_d     = is_prime_q;
		last_of_run_d  = last_of_run_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					num_d  = candidate;
					last_d = range_end;
					shift_d = candidate;
					rem_d  = '0;
					div_d  = NUM_WIDTH'(2);
					cnt_d  = '0;
					// no divisor to try for candidates below four
					if ((candidate >> 2) == '0) begin
						done_d         = 1'b1;
						tested_value_d = candidate;
						is_prime_d     = (candidate >= NUM_WIDTH'(2));
						last_of_run_d  = range_end;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				shift_d = shift_q << 1;
				rem_d   = rem_step;
				cnt_d   = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					// remainder complete for this divisor
					if (rem_step == '0 || div_q == limit) begin
						done_d         = 1'b1;
						tested_value_d = num_q;
						is_prime_d     = (rem_step != '0);
						last_of_run_d  = last_q;
						state_d        = ST_IDLE;
					end else begin
						div_d   = div_q + NUM_WIDTH'(1);
						shift_d = num_q;
						rem_d   = '0;
						cnt_d   = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		num_q          <= num_d;
		last_q         <= last_d;
		shift_q        <= shift_d;
		rem_q          <= rem_d;
		div_q          <= div_d;
		cnt_q          <= cnt_d;
		tested_value_q <= tested_value_d;
		is_prime_q     <= is_prime_d;
		last_of_run_q  <= last_of_run_d;
	end

	// result transfer
	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign tested_value = tested_value_q;
	assign is_prime     = is_prime_q;
	assign last_of_run  = last_of_run_q;

endmodule : trial_division_prime_test

`default_nettype wire

/* tb/prime_verdict_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_verdict_monitor
// Watches the candidate and verdict channels of the trial-division prime
// tester. Each candidate transfer is turned into an expected verdict by plain
// trial division. Each done strobe is compared field by field with the oldest
// expected verdict.
// ----------------------------------------------------------------------------

module prime_verdict_monitor #(
	parameter int NUM_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [NUM_WIDTH-1:0] candidate,
	input  wire logic                 range_end,
	input  wire logic                 done,
	input  wire logic [NUM_WIDTH-1:0] tested_value,
	input  wire logic                 is_prime,
	input  wire logic                 last_of_run,
	output int                        mismatches,
	output int                        outstanding,
	output int                        verdicts,
	output int                        primes_seen
);

	typedef struct packed {
		logic [NUM_WIDTH-1:0] value;
		logic                 prime;
		logic                 last;
	} verdict_t;

	verdict_t verdicts_due[$];

	// divisors from 2 up to n/2, stop at the first exact one
	function automatic logic primality_of(input logic [NUM_WIDTH-1:0] n);
		int unsigned divisor;
		if (n < 2)
			return 1'b0;
		for (divisor = 2; divisor <= n / 2; divisor++) begin
			if (n % divisor == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		verdicts    = 0;
		primes_seen = 0;
	end

	always @(posedge clk) begin
		verdict_t due;
		if (arst_n) begin
			// verdict out: match against the oldest pending candidate
			if (done) begin
				if (verdicts_due.size() == 0) begin
					$error("tested_value: verdict for %0d with nothing pending", tested_value);
					mismatches++;
				end else begin
					due = verdicts_due.pop_front();
					verdicts++;
					if (due.prime)
						primes_seen++;
					if (tested_value !== due.value) begin
						$error("tested_value: expected %0d, actual %0d", due.value, tested_value);
						mismatches++;
					end
					if (is_prime !== due.prime) begin
						$error("is_prime: expected %0d, actual %0d (candidate %0d)",
							due.prime, is_prime, due.value);
						mismatches++;
					end
					if (last_of_run !== due.last) begin
						$error("last_of_run: expected %0d, actual %0d (candidate %0d)",
							due.last, last_of_run, due.value);
						mismatches++;
					end
				end
			end
			// candidate transfer in
			if (start && !busy)
				verdicts_due.push_back('{candidate, primality_of(candidate), range_end});
			outstanding = verdicts_due.size();
		end
	end

endmodule

/* tb/trial_division_prime_test_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_test
// Drives candidates into the trial-division prime tester: a directed set of
// edge values, then random short intervals, small singles and large
// composites, with random gaps between transfers. Checking is done by the
// verdict monitor alongside the block.
// ----------------------------------------------------------------------------

module trial_division_prime_test_test;

	localparam int NUM_WIDTH    = 16;
	localparam int RANDOM_ITEMS = 76;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 20_000_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic [NUM_WIDTH-1:0] candidate = '0;
	logic                 range_end = 1'b0;
	wire                  busy;
	wire                  done;
	wire  [NUM_WIDTH-1:0] tested_value;
	wire                  is_prime;
	wire                  last_of_run;

	int mismatches;
	int outstanding;
	int verdicts;
	int primes_seen;
	int sent        = 0;
	int directed    = 0;
	int cycle_count = 0;
	bit bursty      = 1'b0;
	int small_factors[7] = '{2, 3, 5, 7, 11, 13, 251};

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	trial_division_prime_test #(
		.NUM_WIDTH(NUM_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.candidate(candidate),
		.range_end(range_end),
		.done(done),
		.tested_value(tested_value),
		.is_prime(is_prime),
		.last_of_run(last_of_run)
	);

	prime_verdict_monitor #(
		.NUM_WIDTH(NUM_WIDTH)
	) u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.candidate(candidate),
		.range_end(range_end),
		.done(done),
		.tested_value(tested_value),
		.is_prime(is_prime),
		.last_of_run(last_of_run),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.verdicts(verdicts),
		.primes_seen(primes_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("run stopped after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// one candidate transfer, after an optional idle gap
	task automatic offer_candidate(input logic [NUM_WIDTH-1:0] value, input logic last);
		int gap;
		gap = bursty ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		candidate <= value;
		range_end <= last;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	// consecutive candidates, the last one flagged as interval end
	task automatic walk_interval(input int first, input int length);
		for (int i = 0; i < length; i++)
			offer_candidate(NUM_WIDTH'(first + i), i == length - 1);
	endtask

	initial begin
		int kind;
		int factor;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero and one, two and three, small squares, field extremes
		offer_candidate(0, 1'b0);
		offer_candidate(1, 1'b1);
		offer_candidate(2, 1'b0);
		offer_candidate(3, 1'b1);
		offer_candidate(4, 1'b0);
		offer_candidate(9, 1'b0);
		offer_candidate(25, 1'b1);
		offer_candidate(49, 1'b0);
		offer_candidate(257, 1'b1);
		offer_candidate(65535, 1'b1);
		offer_candidate(65534, 1'b0);
		offer_candidate(32768, 1'b0);
		offer_candidate(64507, 1'b1);
		offer_candidate(4093, 1'b0);
		offer_candidate(4096, 1'b1);
		// largest 16-bit prime: the slowest case
		offer_candidate(65521, 1'b1);
		bursty = 1'b1;
		walk_interval(14, 4);
		bursty = 1'b0;
		walk_interval(0, 4);
		directed = sent;

		// random: mostly short intervals, some singles and big composites
		while (sent - directed < RANDOM_ITEMS) begin
			bursty = ($urandom_range(0, 3) == 0);
			kind   = $urandom_range(0, 9);
			if (kind < 6) begin
				walk_interval($urandom_range(0, 300), $urandom_range(1, 8));
			end else if (kind < 8) begin
				offer_candidate(NUM_WIDTH'($urandom_range(0, 4095)),
					1'($urandom_range(0, 1)));
			end else begin
				factor = small_factors[$urandom_range(0, 6)];
				offer_candidate(NUM_WIDTH'(factor * $urandom_range(1, 65535 / factor)),
					1'($urandom_range(0, 1)));
			end
		end
		start <= 1'b0;

		// drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (outstanding != 0)
			$error("%0d verdicts never arrived", outstanding);
		$display("covered %0d candidates (%0d directed, %0d random) in %0d cycles",
			sent, directed, sent - directed, cycle_count);
		$display("%0d verdicts checked, %0d of them prime", verdicts, primes_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
